[design/rdfm_pkg.sv]
// Shared types, symbol codes and site matching for the restriction digest fragment masker.
package rdfm_pkg;

    // Symbol codes on the input stream and in the delay line
    typedef logic [2:0] sym_t;

    localparam sym_t SYM_A  = 3'd0;
    localparam sym_t SYM_C  = 3'd1;
    localparam sym_t SYM_G  = 3'd2;
    localparam sym_t SYM_T  = 3'd3;
    localparam sym_t SYM_N  = 3'd4;
    localparam sym_t SYM_NL = 3'd5;

    // Recognition sites, element 0 is the first letter
    typedef sym_t [3:0] site_t;

    localparam site_t SITE_MSPI = {SYM_G, SYM_G, SYM_C, SYM_C};
    localparam site_t SITE_TAQI = {SYM_A, SYM_G, SYM_C, SYM_T};

    // Lookahead window, element 0 is the head symbol
    typedef sym_t [4:0] win_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_BASES  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TAQI_ENABLE = 2'd1;

    localparam logic [5:0] KEEP_BASES_RESET = 6'd39;

    // Input item
    typedef struct packed {
        logic [2:0] symbol;
        logic       sequence_end;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic       has_base;
        logic [2:0] base_out;
        logic       newline_after;
        logic       fragment_end;
        logic       run_last;
    } out_item_t;

    // One delay line entry: a base and its trailing line break flag
    typedef struct packed {
        logic nl;
        sym_t base;
    } entry_t;

    // Per-cell controls of the delay line
    typedef struct packed {
        logic shift;
        logic load;
        logic set_nl;
    } cell_ctrl_t;

    // Site match at the window head: plain, or with one line break between letters
    function automatic logic match_site(win_t w, logic [2:0] wl, site_t site);
        logic hit;
        logic direct;
        logic gapped;
        int   p;
        direct = (wl >= 3'd4);
        for (int i = 0; i < 4; i++) begin
            if (w[i] != site[i]) direct = 1'b0;
        end
        hit = direct;
        if (wl == 3'd5) begin
            for (int gap = 1; gap < 4; gap++) begin
                gapped = 1'b1;
                p = 0;
                for (int i = 0; i < 5; i++) begin
                    if (i == gap) begin
                        if (w[i] != SYM_NL) gapped = 1'b0;
                    end else begin
                        if (w[i] != site[p[1:0]]) gapped = 1'b0;
                        p++;
                    end
                end
                hit = hit | gapped;
            end
        end
        return hit;
    endfunction

endpackage

[design/restriction_digest_fragment_masker.sv]
// Top level: lookahead window, sequencer and delay line chain of the fragment masker.
//
//   channel   ports                        direction  payload
//   s_        s_valid  s_ready  s_data     in         in_item_t (symbol, sequence_end)
//   m_        m_valid  m_ready  m_data     out        out_item_t
//   cfg_      cfg_valid cfg_ready          in         cfg_index, cfg_data
//
// A symbol that only fills the window is stored. One that moves a head out of the window
// takes the sequencer through head, trim, flush (at a cut) and done; at sequence end the
// held heads follow in turn. One base leaves cell 0 of the delay line per cycle while the
// output can take it, which sets the burst rate at a cut. Reset (aresetn, synchronous)
// empties window and delay line by their fill counts; cell contents are not cleared. A
// low m_ready holds the sequencer at its next result; s_ready is high only between items.
module restriction_digest_fragment_masker import rdfm_pkg::*; #(
    parameter int MAX_KEEP = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int FW        = $clog2(MAX_KEEP + 1);
    localparam int IW        = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int COUNT_SAT = 2 * MAX_KEEP + 1;
    localparam int CW        = $clog2(COUNT_SAT + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HEAD  = 3'd1;
    localparam logic [2:0] ST_TRIM  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    win_t          win_reg, win_next;
    logic [2:0]    wlen_reg, wlen_next;
    logic          drain_reg, drain_next;
    logic          cut_reg, cut_next;
    logic          trim_reg, trim_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [CW-1:0] count_reg, count_next;
    logic [5:0]    keep_reg;
    logic          taqi_reg;
    logic          pend_valid_reg, pend_valid_next;
    out_item_t     pend_reg, pend_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_item_reg, m_item_next;

    logic          cell_shift;
    logic          load_en;
    logic [IW-1:0] load_idx;
    logic          nl_en;
    logic [IW-1:0] nl_idx;
    entry_t        cell_din;
    entry_t        cell_q [MAX_KEEP];

    logic [FW-1:0] eff_keep;
    logic [FW-1:0] depth;
    logic [CW-1:0] idx;
    logic [FW-1:0] from_end;
    logic          keep_ok;
    logic          full;
    logic          out_free;
    logic          can_emit;
    logic          emit;
    logic          emit_bare;
    logic          emit_fe;
    out_item_t     emit_item;
    logic          head_cut;
    logic          after_done;
    logic [2:0]    after_flush;
    sym_t          in_sym;
    sym_t          head_sym;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_item_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= KEEP_BASES_RESET;
            taqi_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_KEEP_BASES:  keep_reg <= cfg_data[5:0];
                CFG_TAQI_ENABLE: taqi_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Masking of the oldest held base
    assign eff_keep = (keep_reg > 6'(MAX_KEEP)) ? FW'(MAX_KEEP) : FW'(keep_reg);
    assign depth    = (eff_keep == '0) ? FW'(1) : eff_keep;
    assign idx      = count_reg - CW'(fill_reg);
    assign from_end = fill_reg - FW'(1);
    assign keep_ok  = (idx < CW'(eff_keep)) || (from_end < eff_keep);
    assign full     = (fill_reg == FW'(MAX_KEEP));

    always_comb begin
        emit_item               = '0;
        emit_item.has_base      = !emit_bare;
        emit_item.base_out      = emit_bare ? SYM_A : (keep_ok ? cell_q[0].base : SYM_N);
        emit_item.newline_after = emit_bare ? 1'b0 : cell_q[0].nl;
        emit_item.fragment_end  = emit_fe;
        emit_item.run_last      = 1'b0;
    end

    // Cut decision at the window head
    assign head_sym = win_reg[0];
    always_comb begin
        head_cut = 1'b0;
        if (head_sym == SYM_T && taqi_reg) begin
            head_cut = match_site(win_reg, wlen_reg, SITE_TAQI);
        end else if (head_sym == SYM_C) begin
            head_cut = match_site(win_reg, wlen_reg, SITE_MSPI);
        end
    end

    assign in_sym      = (s_data.symbol > SYM_NL) ? SYM_N : s_data.symbol;
    assign out_free    = !m_valid_reg || m_ready;
    assign can_emit    = !pend_valid_reg || out_free;
    assign after_done  = drain_reg && (wlen_reg != 3'd0);
    assign after_flush = after_done ? ST_HEAD : ST_DONE;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        win_next        = win_reg;
        wlen_next       = wlen_reg;
        drain_next      = drain_reg;
        cut_next        = cut_reg;
        trim_next       = trim_reg;
        fill_next       = fill_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_item_next     = m_item_reg;
        cell_shift      = 1'b0;
        load_en         = 1'b0;
        load_idx        = full ? IW'(fill_reg - FW'(1)) : IW'(fill_reg);
        nl_en           = 1'b0;
        nl_idx          = IW'(fill_reg - FW'(1));
        cell_din        = '{nl: 1'b0, base: head_sym};
        emit            = 1'b0;
        emit_bare       = 1'b0;
        emit_fe         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    win_next[wlen_reg] = in_sym;
                    wlen_next          = wlen_reg + 3'd1;
                    drain_next         = s_data.sequence_end;
                    if (s_data.sequence_end || wlen_reg == 3'd4) begin
                        state_next = ST_HEAD;
                    end
                end
            end
            ST_HEAD: begin
                if (head_sym == SYM_NL) begin
                    if (fill_reg == '0) begin
                        if (can_emit) begin
                            emit       = 1'b1;
                            emit_bare  = 1'b1;
                            state_next = ST_TRIM;
                        end
                    end else begin
                        nl_en      = 1'b1;
                        state_next = ST_TRIM;
                    end
                end else if (full) begin
                    // oldest leaves as the new base enters the tail
                    if (can_emit) begin
                        emit       = 1'b1;
                        cell_shift = 1'b1;
                        load_en    = 1'b1;
                        state_next = ST_TRIM;
                    end
                end else begin
                    load_en    = 1'b1;
                    fill_next  = fill_reg + FW'(1);
                    state_next = ST_TRIM;
                end
                if (state_next == ST_TRIM) begin
                    cut_next  = head_cut;
                    // only a new base trims the line to a smaller depth
                    trim_next = (head_sym != SYM_NL);
                    if (head_sym != SYM_NL && count_reg < CW'(COUNT_SAT)) begin
                        count_next = count_reg + CW'(1);
                    end
                    for (int i = 0; i < 4; i++) begin
                        win_next[i] = win_reg[i+1];
                    end
                    wlen_next = wlen_reg - 3'd1;
                end
            end
            ST_TRIM: begin
                if (trim_reg && fill_reg > depth) begin
                    if (can_emit) begin
                        emit       = 1'b1;
                        cell_shift = 1'b1;
                        fill_next  = fill_reg - FW'(1);
                    end
                end else if (cut_reg) begin
                    state_next = ST_FLUSH;
                end else if (after_done) begin
                    state_next = ST_HEAD;
                end else if (drain_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FLUSH: begin
                if (fill_reg == '0) begin
                    count_next = '0;
                    state_next = after_flush;
                end else if (can_emit) begin
                    emit       = 1'b1;
                    emit_fe    = (fill_reg == FW'(1));
                    cell_shift = 1'b1;
                    fill_next  = fill_reg - FW'(1);
                    if (fill_reg == FW'(1)) begin
                        count_next = '0;
                        state_next = after_flush;
                    end
                end
            end
            ST_DONE: begin
                // last result of the item leaves with run_last set
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_item_next          = pend_reg;
                    m_item_next.run_last = 1'b1;
                    m_valid_next         = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new result parks in the pending slot; the previous one moves out
        if (emit) begin
            if (pend_valid_reg) begin
                m_item_next  = pend_reg;
                m_valid_next = 1'b1;
            end
            pend_next       = emit_item;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wlen_reg       <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wlen_reg       <= wlen_next;
            fill_reg       <= fill_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg    <= win_next;
        drain_reg  <= drain_next;
        cut_reg    <= cut_next;
        trim_reg   <= trim_next;
        pend_reg   <= pend_next;
        m_item_reg <= m_item_next;
    end

    // Delay line: a row of cells, oldest entry in cell 0
    for (genvar gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
        cell_ctrl_t ctrl;
        entry_t     right_q;

        assign ctrl.shift  = cell_shift;
        assign ctrl.load   = load_en && (load_idx == IW'(gi));
        assign ctrl.set_nl = nl_en && (nl_idx == IW'(gi));

        if (gi < MAX_KEEP - 1) begin : g_mid
            assign right_q = cell_q[gi+1];
        end else begin : g_last
            assign right_q = '0;
        end

        rdfm_cell u_cell (
            .aclk    (aclk),
            .ctrl    (ctrl),
            .din     (cell_din),
            .right_q (right_q),
            .q       (cell_q[gi])
        );
    end

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(MAX_KEEP))
        else $error("delay line fill beyond its cells");

    a_count_covers_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg >= CW'(fill_reg))
        else $error("fragment count below held bases");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg && wlen_reg <= 3'd4)
        else $error("idle with a pending result or an overfull window");

    a_flush_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH && state_next != ST_FLUSH) |=> fill_reg == '0 && count_reg == '0)
        else $error("fragment not empty after flush");

endmodule

[design/rdfm_cell.sv]
// One delay line cell: holds an entry, loads a new base, takes its neighbor on shift.
module rdfm_cell import rdfm_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  entry_t     din,
    input  entry_t     right_q,
    output entry_t     q
);

    entry_t q_reg;
    entry_t q_next;

    // load wins over shift; the tail cell may load while the line shifts
    always_comb begin
        q_next = q_reg;
        if (ctrl.load) begin
            q_next = din;
        end else if (ctrl.shift) begin
            q_next = right_q;
        end else if (ctrl.set_nl) begin
            q_next.nl = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[verif/restriction_digest_fragment_masker_test.sv]
// Self-checking testbench for the restriction digest fragment masker, directed and random chromosomes.
module restriction_digest_fragment_masker_test;
    import rdfm_pkg::*;

    localparam int MAX_KEEP    = 48;
    localparam int COUNT_LIMIT = 2 * MAX_KEEP + 1;
    localparam int RESULT_CAP  = 54;
    localparam int SETTLE      = 16;

    // Index codes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Symbol codes outside the alphabet, taken as N
    localparam sym_t SYM_RSVD6 = 3'd6;
    localparam sym_t SYM_RSVD7 = 3'd7;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    restriction_digest_fragment_masker #(.MAX_KEEP(MAX_KEEP)) uut (.*);

    // Predictor state: lookahead window, held bases of the open fragment, registers
    sym_t        win_syms [4];
    int unsigned win_fill;
    sym_t        head_buf [5];
    entry_t      held [MAX_KEEP];
    int unsigned held_cnt;
    int unsigned frag_len;
    logic [5:0]  keep_reg;
    logic        taqi_on;
    int unsigned step_results;
    out_item_t   masked_out [$];

    int unsigned mismatches;
    int          gap_mode;
    int          stall_mode;
    int          stall_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void reset_model();
        win_fill = 0;
        held_cnt = 0;
        frag_len = 0;
        keep_reg = KEEP_BASES_RESET;
        taqi_on  = 1'b0;
        masked_out.delete();
    endfunction

    function automatic int unsigned kept_span();
        return (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
    endfunction

    function automatic void post_result(logic has, sym_t base, logic nl, logic fe);
        out_item_t r;
        if (step_results >= RESULT_CAP) return;
        r = '{has_base: has, base_out: base, newline_after: nl, fragment_end: fe,
              run_last: 1'b0};
        masked_out.push_back(r);
        step_results++;
    endfunction

    // Oldest held base leaves; masked unless near either end of its fragment
    function automatic void release_oldest(logic fe);
        int unsigned k;
        int unsigned idx;
        int unsigned from_end;
        sym_t        base;
        k        = kept_span();
        idx      = frag_len - held_cnt;
        from_end = held_cnt - 1;
        base     = held[0].base;
        if (!(idx < k || from_end < k)) base = SYM_N;
        post_result(1'b1, base, held[0].nl, fe);
        for (int i = 0; i + 1 < held_cnt; i++) held[i] = held[i + 1];
        held_cnt--;
    endfunction

    function automatic void close_fragment();
        while (held_cnt > 0) release_oldest(held_cnt == 1);
        frag_len = 0;
    endfunction

    function automatic void hold_symbol(sym_t s);
        int unsigned depth;
        if (s == SYM_NL) begin
            // bare break goes out at once; a second break after a base is dropped
            if (held_cnt == 0) post_result(1'b0, SYM_A, 1'b0, 1'b0);
            else held[held_cnt - 1].nl = 1'b1;
            return;
        end
        depth = (kept_span() == 0) ? 1 : kept_span();
        if (held_cnt >= MAX_KEEP) release_oldest(1'b0);
        held[held_cnt] = '{nl: 1'b0, base: s};
        held_cnt++;
        if (frag_len < COUNT_LIMIT) frag_len++;
        while (held_cnt > depth) release_oldest(1'b0);
    endfunction

    // Site at head_buf[off], plain or with one break between two letters
    function automatic logic site_at(int off, int rem, site_t site);
        logic hit;
        logic ok;
        int   p;
        hit = 1'b0;
        if (rem >= 4) begin
            ok = 1'b1;
            for (int i = 0; i < 4; i++) if (head_buf[off + i] != site[i]) ok = 1'b0;
            hit = ok;
        end
        if (rem >= 5) begin
            for (int gap = 1; gap < 4; gap++) begin
                ok = 1'b1;
                p  = 0;
                for (int i = 0; i < 5; i++) begin
                    if (i == gap) begin
                        if (head_buf[off + i] != SYM_NL) ok = 1'b0;
                    end else begin
                        if (head_buf[off + i] != site[p]) ok = 1'b0;
                        p++;
                    end
                end
                if (ok) hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void take_head(int off, int rem);
        logic cut;
        sym_t h;
        h   = head_buf[off];
        cut = 1'b0;
        if (h == SYM_T && taqi_on) cut = site_at(off, rem, SITE_TAQI);
        else if (h == SYM_C) cut = site_at(off, rem, SITE_MSPI);
        hold_symbol(h);
        if (cut) close_fragment();
    endfunction

    // Expected outputs for one accepted symbol
    function automatic void digest_symbol(in_item_t item);
        sym_t      s;
        int        len;
        out_item_t last;
        s = (item.symbol > SYM_NL) ? SYM_N : item.symbol;
        for (int i = 0; i < 4; i++) head_buf[i] = win_syms[i];
        head_buf[win_fill] = s;
        len = win_fill + 1;
        step_results = 0;
        if (item.sequence_end) begin
            for (int i = 0; i < len; i++) take_head(i, len - i);
            close_fragment();
            win_fill = 0;
        end else if (len == 5) begin
            take_head(0, 5);
            for (int i = 0; i < 4; i++) win_syms[i] = head_buf[i + 1];
            win_fill = 4;
        end else begin
            for (int i = 0; i < 4; i++) win_syms[i] = head_buf[i];
            win_fill = len;
        end
        if (step_results > 0) begin
            last = masked_out.pop_back();
            last.run_last = 1'b1;
            masked_out.push_back(last);
        end
    endfunction

    // Track accepted transfers and check every result against the oldest prediction
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_KEEP_BASES) keep_reg = cfg_data[5:0];
                else if (cfg_index == CFG_TAQI_ENABLE) taqi_on = cfg_data[0];
            end
            if (s_valid && s_ready) digest_symbol(s_data);
            if (m_valid && m_ready) begin
                if (masked_out.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: has=%0d base=%0d nl=%0d fe=%0d last=%0d",
                                 m_data.has_base, m_data.base_out, m_data.newline_after,
                                 m_data.fragment_end, m_data.run_last);
                    mismatches++;
                end else begin
                    want = masked_out.pop_front();
                    if (m_data.has_base !== want.has_base ||
                        m_data.base_out !== want.base_out ||
                        m_data.newline_after !== want.newline_after ||
                        m_data.fragment_end !== want.fragment_end ||
                        m_data.run_last !== want.run_last) begin
                        if (mismatches < 10)
                            $display("mismatch: expected has=%0d base=%0d nl=%0d fe=%0d last=%0d, %s",
                                     want.has_base, want.base_out, want.newline_after,
                                     want.fragment_end, want.run_last,
                                     $sformatf("got has=%0d base=%0d nl=%0d fe=%0d last=%0d",
                                               m_data.has_base, m_data.base_out,
                                               m_data.newline_after, m_data.fragment_end,
                                               m_data.run_last));
                        mismatches++;
                    end
                end
            end
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(int mode);
        int r;
        if (mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Receiver stalls
    always @(negedge aclk) begin
        if (stall_left == 0 && stall_mode != 0) stall_left = pick_gap(1);
        m_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
    end

    // One symbol transfer; entered and left at a falling edge
    task automatic send_symbol(sym_t sym, logic last);
        int gap;
        gap = pick_gap(gap_mode);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{symbol: sym, sequence_end: last};
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_symbols(input sym_t syms[$], input logic close);
        foreach (syms[i]) send_symbol(syms[i], close && (i == syms.size() - 1));
    endtask

    // Wait for every predicted result, then let the sequencer settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (masked_out.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic set_config(logic [7:0] keep_data, logic [7:0] taqi_data);
        drain_results();
        write_reg(CFG_KEEP_BASES, keep_data);
        write_reg(CFG_TAQI_ENABLE, taqi_data);
        write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Reset registers: TaqI is off, so TCGA does not cut; then keep drops to 0 mid fragment
    task automatic test_defaults();
        sym_t part [$];
        part = '{SYM_T, SYM_C, SYM_G, SYM_A, SYM_N};
        send_symbols(part, 1'b0);
        drain_results();
        write_reg(CFG_KEEP_BASES, 8'd0);
        cfg_valid <= 1'b0;
        part = '{SYM_C, SYM_A};
        send_symbols(part, 1'b1);
    endtask

    // Plain and broken sites, bare and repeated breaks, unknown codes, partial site at the end
    task automatic test_sites_and_breaks();
        sym_t part [$];
        set_config(8'd1, 8'd1);
        gap_mode   = 1;
        stall_mode = 1;
        part = '{SYM_NL, SYM_C, SYM_C, SYM_G, SYM_G, SYM_NL, SYM_NL, SYM_T,
                 SYM_C, SYM_NL, SYM_G, SYM_A, SYM_RSVD6, SYM_C, SYM_NL, SYM_NL,
                 SYM_C, SYM_G, SYM_G, SYM_RSVD7, SYM_C, SYM_C, SYM_G};
        send_symbols(part, 1'b1);
    endtask

    // Random chromosomes, mostly bases and sites with some breaks and noise
    task automatic run_phase(logic [7:0] keep_data, logic [7:0] taqi_data, int total,
                             int min_len, int max_len, int site_pct);
        sym_t  chrom [$];
        site_t motif;
        int    sent;
        int    len;
        int    r;
        int    kind;
        int    brk;
        set_config(keep_data, taqi_data);
        sent = 0;
        while (sent < total) begin
            chrom.delete();
            len = $urandom_range(min_len, max_len);
            while (chrom.size() < len) begin
                r = $urandom_range(0, 99);
                if (r < site_pct) begin
                    motif = ($urandom_range(0, 1) != 0) ? SITE_MSPI : SITE_TAQI;
                    kind  = $urandom_range(0, 9);
                    brk   = $urandom_range(1, 3);
                    for (int i = 0; i < 4; i++) begin
                        if (kind == 9 && i == 3) break;    // truncated site
                        if (i == brk && kind >= 6) chrom.push_back(SYM_NL);
                        if (i == brk && kind == 8) chrom.push_back(SYM_NL);    // two breaks, no cut
                        chrom.push_back(motif[i]);
                    end
                end else if (r < site_pct + 15) begin
                    chrom.push_back(SYM_NL);
                end else if (r < site_pct + 19) begin
                    chrom.push_back(sym_t'($urandom_range(4, 7)));
                end else begin
                    chrom.push_back(sym_t'($urandom_range(0, 3)));
                end
            end
            gap_mode   = int'($urandom_range(0, 3) != 0);
            stall_mode = int'($urandom_range(0, 3) != 0);
            send_symbols(chrom, 1'b1);
            sent += chrom.size();
        end
    endtask

    task automatic test_random_digest();
        run_phase(8'd0, 8'h00, 10, 3, 12, 12);
        run_phase(8'd1, 8'h81, 10, 3, 14, 12);
        // 63 acts as the maximum; one long fragment outgrows the delay line
        run_phase(8'hFF, 8'h01, 64, 64, 70, 0);
        run_phase(8'd48, 8'hFE, 10, 5, 20, 10);
        repeat (2) run_phase(8'($urandom_range(2, 9)), 8'($urandom), 10, 3, 20, 12);
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_KEEP_BASES;
        cfg_data   = '0;
        gap_mode   = 0;
        stall_mode = 0;
        stall_left = 0;
        mismatches = 0;
        reset_model();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_sites_and_breaks();
        test_random_digest();

        drain_results();
        if (mismatches == 0 && masked_out.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Run limit
    initial begin
        #30000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
